// ===== rtl/core/hls_color_shade_assert.svh =====
// Assertion macros shared by the shading pipeline.
// All of them sample on the rising edge of clock and are disabled while reset is high.
`ifndef HLS_COLOR_SHADE_ASSERT_SVH
`define HLS_COLOR_SHADE_ASSERT_SVH

// Condition in the same cycle.
`define HCS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hcs check failed");

// Condition in the next cycle.
`define HCS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hcs check failed");

`endif

// ===== rtl/core/hcs_pkg.sv =====
package hcs_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;
   localparam int FX_W      = FRAC_BITS + 1;           // 0 .. 1.0
   localparam logic [FX_W-1:0] FX_ONE  = FX_W'(1) << FRAC_BITS;
   localparam logic [FX_W-1:0] FX_HALF = FX_W'(1) << (FRAC_BITS - 1);

   // divider geometry: quotient 0 .. 1.0, two steps per stage
   localparam int QUO_W      = FX_W;
   localparam int DEN_W      = FX_W + 1;
   localparam int REM_W      = DEN_W + 1;
   localparam int DIV_STEPS  = FRAC_BITS + 1;
   localparam int DIV_PER_ST = 2;
   localparam int DIV_STAGES = (DIV_STEPS + DIV_PER_ST - 1) / DIV_PER_ST;

   // register map
   localparam logic REG_SHADE = 1'b0;
   localparam logic [17:0] SHADE_RESET = 18'd65536;

   // channel c to fraction (c << 16) / 255 = 257c + (c == 255)
   function automatic logic [FX_W-1:0] expand(input logic [7:0] c);
      return FX_W'({c, c}) + FX_W'(c == 8'hFF);
   endfunction

   // fraction to channel: (v * 255) >> 16, clamped
   function automatic logic [7:0] to_channel(input logic [FX_W:0] v);
      logic [FX_W+8:0] p;
      logic [9:0]      r;
      p = ({(FX_W+9)'(v)} << 8) - (FX_W+9)'(v);
      r = 10'(p >> FRAC_BITS);
      return (r > 10'd255) ? 8'hFF : r[7:0];
   endfunction

endpackage

// ===== rtl/core/hcs_div.sv =====
// Pipelined restoring divider: quo = (num << 16) / den for num <= den.
// Two quotient bits per stage; each stage advances on its own enable.
module hcs_div (
   input  logic                               clock,
   input  logic [hcs_pkg::DIV_STAGES-1:0]     stage_en,
   input  logic [hcs_pkg::QUO_W-1:0]          num,
   input  logic [hcs_pkg::DEN_W-1:0]          den,
   output logic [hcs_pkg::QUO_W-1:0]          quo
);

   logic [hcs_pkg::REM_W-1:0] rem_ff [hcs_pkg::DIV_STAGES];
   logic [hcs_pkg::REM_W-1:0] rem_in [hcs_pkg::DIV_STAGES];
   logic [hcs_pkg::DEN_W-1:0] den_ff [hcs_pkg::DIV_STAGES];
   logic [hcs_pkg::DEN_W-1:0] den_src [hcs_pkg::DIV_STAGES];
   logic [hcs_pkg::REM_W-1:0] rem_src [hcs_pkg::DIV_STAGES];
   logic [hcs_pkg::QUO_W-1:0] quo_ff [hcs_pkg::DIV_STAGES];
   logic [hcs_pkg::QUO_W-1:0] quo_in [hcs_pkg::DIV_STAGES];
   logic [hcs_pkg::QUO_W-1:0] quo_src [hcs_pkg::DIV_STAGES];

   // stage inputs: first stage from the ports, others from the previous stage
   always_comb begin
      for (int j = 0; j < hcs_pkg::DIV_STAGES; j++) begin
         if (j == 0) begin
            rem_src[j] = hcs_pkg::REM_W'(num);
            den_src[j] = den;
            quo_src[j] = '0;
         end else begin
            rem_src[j] = rem_ff[j-1];
            den_src[j] = den_ff[j-1];
            quo_src[j] = quo_ff[j-1];
         end
      end
   end

   // compare / subtract steps; the first step takes the integer bit unshifted
   always_comb begin
      logic [hcs_pkg::REM_W-1:0] r;
      logic [hcs_pkg::QUO_W-1:0] q;
      for (int j = 0; j < hcs_pkg::DIV_STAGES; j++) begin
         r = rem_src[j];
         q = quo_src[j];
         for (int k = 0; k < hcs_pkg::DIV_PER_ST; k++) begin
            if (j * hcs_pkg::DIV_PER_ST + k < hcs_pkg::DIV_STEPS) begin
               if (j * hcs_pkg::DIV_PER_ST + k != 0) r = r << 1;
               if (r >= hcs_pkg::REM_W'(den_src[j])) begin
                  r = r - hcs_pkg::REM_W'(den_src[j]);
                  q = {q[hcs_pkg::QUO_W-2:0], 1'b1};
               end else begin
                  q = {q[hcs_pkg::QUO_W-2:0], 1'b0};
               end
            end
         end
         rem_in[j] = r;
         quo_in[j] = q;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < hcs_pkg::DIV_STAGES; j++) begin
         if (stage_en[j]) begin
            rem_ff[j] <= rem_in[j];
            den_ff[j] <= den_src[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign quo = quo_ff[hcs_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/core/hls_color_shade.sv =====
// RGBA pixel shader through an RGB -> HLS -> RGB round trip.
// Input stream req_*: one pixel per transfer, tdata = {alpha, blue, green, red}.
// Output stream rsp_*: the shaded pixel, same packing; alpha is copied.
// Config port csr_* (APB style, pready always high): register 0 at byte
// address 0 is shade_factor, an 18-bit 2.16 multiplier for luminance and
// saturation. Write it only while no pixel is in flight.
// Pipeline: 16 register stages (one input stage, nine divider stages at two
// quotient bits each, six shading stages), the last of which is the output register.
// Throughput: one pixel per clock while rsp_tready is high; every stage holds a valid bit and loads
// whenever it is empty or its successor loads, so bubbles close up.
// When the receiver stalls, the output register holds its pixel and the
// stages behind it keep filling; req_tready falls only once all are full.
// Reset clears all valid bits and sets shade_factor to 1.0 (65536).
module hls_color_shade (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red_in, green_in, blue_in, alpha_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // red_out, green_out, blue_out, alpha_out
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   `include "hls_color_shade_assert.svh"

   localparam int FB = hcs_pkg::FRAC_BITS;
   localparam int FW = hcs_pkg::FX_W;
   localparam int NS = hcs_pkg::DIV_STAGES;
   localparam int HW = FW + 9;   // hue in degrees, fixed point, unsigned
   localparam logic signed [HW+1:0] DEG60  = (HW+2)'(60)  <<< FB;
   localparam logic signed [HW+1:0] DEG120 = (HW+2)'(120) <<< FB;
   localparam logic signed [HW+1:0] DEG180 = (HW+2)'(180) <<< FB;
   localparam logic signed [HW+1:0] DEG240 = (HW+2)'(240) <<< FB;
   localparam logic signed [HW+1:0] DEG360 = (HW+2)'(360) <<< FB;
   localparam int TW = FB + 6;   // ramp argument, up to 60 degrees
   localparam logic [16:0] RECIP60 = 17'd69906;   // ceil(2^22 / 60)

   typedef enum logic [1:0] {SEG_RISE, SEG_HIGH, SEG_FALL, SEG_LOW} seg_type;

   typedef struct packed {
      logic [FW-1:0] lum;
      logic [2:0]    hbase;
      logic          hneg;
      logic          grey;
      logic [7:0]    alpha;
   } side_type;

   // ---------------- configuration ----------------
   logic [17:0] shade_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == hcs_pkg::REG_SHADE) ? {14'd0, shade_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         shade_ff <= hcs_pkg::SHADE_RESET;
      end else if (csr_wr && csr_paddr[2] == hcs_pkg::REG_SHADE) begin
         shade_ff <= csr_pwdata[17:0];
      end
   end

   // ---------------- stage enables ----------------
   logic          v1_ff, va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff;
   logic [NS-1:0] vdiv_ff;
   logic          en1, ena, enb, enc, en_d, ene, enf;
   logic [NS-1:0] en_div;

   assign enf = !vf_ff || rsp_tready;
   assign ene = !ve_ff || enf;
   assign en_d = !vd_ff || ene;
   assign enc = !vc_ff || en_d;
   assign enb = !vb_ff || enc;
   assign ena = !va_ff || enb;

   always_comb begin
      logic nxt;
      nxt = ena;
      for (int j = NS - 1; j >= 0; j--) begin
         en_div[j] = !vdiv_ff[j] || nxt;
         nxt = en_div[j];
      end
   end

   assign en1 = !v1_ff || en_div[0];
   assign req_tready = en1;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         vdiv_ff <= '0;
         va_ff   <= 1'b0;
         vb_ff   <= 1'b0;
         vc_ff   <= 1'b0;
         vd_ff   <= 1'b0;
         ve_ff   <= 1'b0;
         vf_ff   <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         for (int j = 0; j < NS; j++) begin
            if (en_div[j]) vdiv_ff[j] <= (j == 0) ? v1_ff : vdiv_ff[(j == 0) ? 0 : j - 1];
         end
         if (ena) va_ff <= vdiv_ff[NS-1];
         if (enb) vb_ff <= va_ff;
         if (enc) vc_ff <= vb_ff;
         if (en_d) vd_ff <= vc_ff;
         if (ene) ve_ff <= vd_ff;
         if (enf) vf_ff <= ve_ff;
      end
   end

   // ---------------- stage 1: fractions, min / max, divider operands ----------------
   logic [FW-1:0]   r1, g1, b1, mx1, mn1, d1, hnum1;
   logic [FW:0]     sum1, sden1;
   logic signed [FW:0] hsig1;
   side_type        side1;
   logic [FW-1:0]   snum_ff, hnum_ff;
   logic [FW:0]     sden_ff, hden_ff;
   side_type        side1_ff;

   always_comb begin
      r1 = hcs_pkg::expand(req_tdata[7:0]);
      g1 = hcs_pkg::expand(req_tdata[15:8]);
      b1 = hcs_pkg::expand(req_tdata[23:16]);
      mx1 = (r1 > g1) ? r1 : g1;
      if (b1 > mx1) mx1 = b1;
      mn1 = (r1 < g1) ? r1 : g1;
      if (b1 < mn1) mn1 = b1;
      sum1 = {1'b0, mx1} + {1'b0, mn1};
      d1 = mx1 - mn1;
      side1.lum = sum1[FW:1];
      side1.grey = (mx1 == mn1);
      side1.alpha = req_tdata[31:24];
      sden1 = (sum1[FW:1] <= hcs_pkg::FX_HALF) ? sum1 : ((FW+1)'(2) << FB) - sum1;
      if (r1 == mx1) begin
         hsig1 = $signed({1'b0, g1}) - $signed({1'b0, b1});
         side1.hbase = 3'd0;
      end else if (g1 == mx1) begin
         hsig1 = $signed({1'b0, b1}) - $signed({1'b0, r1});
         side1.hbase = 3'd2;
      end else begin
         hsig1 = $signed({1'b0, r1}) - $signed({1'b0, g1});
         side1.hbase = 3'd4;
      end
      side1.hneg = hsig1[FW];
      hnum1 = hsig1[FW] ? FW'(-hsig1) : FW'(hsig1);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         snum_ff  <= d1;
         sden_ff  <= sden1;
         hnum_ff  <= hnum1;
         hden_ff  <= {1'b0, d1};
         side1_ff <= side1;
      end
   end

   // ---------------- divider stages ----------------
   logic [FW-1:0] sq_div, hq_div;
   side_type      side_div_ff [NS];

   hcs_div u_sat_div (
      .clock    (clock),
      .stage_en (en_div),
      .num      (snum_ff),
      .den      (sden_ff),
      .quo      (sq_div)
   );

   hcs_div u_hue_div (
      .clock    (clock),
      .stage_en (en_div),
      .num      (hnum_ff),
      .den      (hden_ff),
      .quo      (hq_div)
   );

   always_ff @(posedge clock) begin
      for (int j = 0; j < NS; j++) begin
         if (en_div[j]) side_div_ff[j] <= (j == 0) ? side1_ff : side_div_ff[(j == 0) ? 0 : j - 1];
      end
   end

   // ---------------- stage A: hue in degrees, shade products ----------------
   side_type             sda;
   logic [FW-1:0]        sa;
   logic signed [FW+3:0] hqa, hsa;
   logic signed [HW+1:0] h60a;
   logic [FW+17:0]       lpa, spa;
   logic [FW+1:0]        lsh_ff, ssh_ff;
   logic [HW-1:0]        ha_ff;
   logic [7:0]           alpha_a_ff;

   always_comb begin
      sda = side_div_ff[NS-1];
      sa = sda.grey ? '0 : sq_div;
      hqa = sda.hneg ? -$signed((FW+4)'(hq_div)) : $signed((FW+4)'(hq_div));
      hsa = $signed((FW+4)'(sda.hbase) <<< FB) + hqa;
      if (sda.grey) hsa = '0;
      h60a = ((HW+2)'(hsa) <<< 6) - ((HW+2)'(hsa) <<< 2);
      if (h60a < 0) h60a = h60a + DEG360;
      lpa = (FW+18)'(sda.lum) * (FW+18)'(shade_ff);
      spa = (FW+18)'(sa) * (FW+18)'(shade_ff);
   end

   always_ff @(posedge clock) begin
      if (ena) begin
         lsh_ff     <= lpa[FB+FW+1:FB];
         ssh_ff     <= spa[FB+FW+1:FB];
         ha_ff      <= HW'(h60a);
         alpha_a_ff <= sda.alpha;
      end
   end

   // ---------------- stage B: clamp, l * s ----------------
   logic [FW-1:0]   lcb, scb;
   logic [2*FW-1:0] pb;
   logic [FW-1:0]   lb_ff, sb_ff, pb_ff;
   logic [HW-1:0]   hb_ff;
   logic [7:0]      alpha_b_ff;

   always_comb begin
      lcb = (lsh_ff > (FW+2)'(hcs_pkg::FX_ONE)) ? hcs_pkg::FX_ONE : lsh_ff[FW-1:0];
      scb = (ssh_ff > (FW+2)'(hcs_pkg::FX_ONE)) ? hcs_pkg::FX_ONE : ssh_ff[FW-1:0];
      pb = (2*FW)'(lcb) * (2*FW)'(scb);
   end

   always_ff @(posedge clock) begin
      if (enb) begin
         lb_ff      <= lcb;
         sb_ff      <= scb;
         pb_ff      <= FW'(pb >> FB);
         hb_ff      <= ha_ff;
         alpha_b_ff <= alpha_a_ff;
      end
   end

   // ---------------- stage C: midpoints, hue legs ----------------
   logic [FW:0]          m2c, m1c;
   logic signed [HW+1:0] hxc;
   seg_type              segc [3];
   logic [TW-1:0]        tc [3];
   logic [FW-1:0]        m1_c_ff, m2_c_ff, diff_c_ff, lum_c_ff;
   logic [TW-1:0]        t_c_ff [3];
   seg_type              seg_c_ff [3];
   logic                 grey_c_ff;
   logic [7:0]           alpha_c_ff;

   always_comb begin
      if (lb_ff <= hcs_pkg::FX_HALF) m2c = {1'b0, lb_ff} + {1'b0, pb_ff};
      else m2c = {1'b0, lb_ff} + {1'b0, sb_ff} - {1'b0, pb_ff};
      m1c = {lb_ff, 1'b0} - m2c;
      for (int i = 0; i < 3; i++) begin
         hxc = $signed((HW+2)'(hb_ff)) + ((i == 0) ? DEG120 : (i == 1) ? '0 : -DEG120);
         if (hxc > DEG360) hxc = hxc - DEG360;
         if (hxc < 0) hxc = hxc + DEG360;
         if (hxc < DEG60) begin
            segc[i] = SEG_RISE;
            tc[i] = TW'(hxc);
         end else if (hxc < DEG180) begin
            segc[i] = SEG_HIGH;
            tc[i] = '0;
         end else if (hxc < DEG240) begin
            segc[i] = SEG_FALL;
            tc[i] = TW'(DEG240 - hxc);
         end else begin
            segc[i] = SEG_LOW;
            tc[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enc) begin
         m1_c_ff    <= m1c[FW-1:0];
         m2_c_ff    <= m2c[FW-1:0];
         diff_c_ff  <= FW'(m2c - m1c);
         lum_c_ff   <= lb_ff;
         grey_c_ff  <= (sb_ff == '0);
         alpha_c_ff <= alpha_b_ff;
         for (int i = 0; i < 3; i++) begin
            t_c_ff[i]   <= tc[i];
            seg_c_ff[i] <= segc[i];
         end
      end
   end

   // ---------------- stage D: ramp products ----------------
   logic [FW+TW-1:0] prodd [3];
   logic [TW-1:0]    prod_d_ff [3];
   logic [FW-1:0]    m1_d_ff, m2_d_ff, lum_d_ff;
   seg_type          seg_d_ff [3];
   logic             grey_d_ff;
   logic [7:0]       alpha_d_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prodd[i] = (FW+TW)'(diff_c_ff) * (FW+TW)'(t_c_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         for (int i = 0; i < 3; i++) begin
            prod_d_ff[i] <= TW'(prodd[i] >> FB);
            seg_d_ff[i]  <= seg_c_ff[i];
         end
         m1_d_ff    <= m1_c_ff;
         m2_d_ff    <= m2_c_ff;
         lum_d_ff   <= lum_c_ff;
         grey_d_ff  <= grey_c_ff;
         alpha_d_ff <= alpha_c_ff;
      end
   end

   // ---------------- stage E: divide by 60 (reciprocal with one correction) ----------------
   logic [TW+16:0] rece [3];
   logic [16:0]    q0e [3];
   logic [TW:0]    q60e [3];
   logic [16:0]    quo_e_ff [3];
   logic [FW-1:0]  m1_e_ff, m2_e_ff, lum_e_ff;
   seg_type        seg_e_ff [3];
   logic           grey_e_ff;
   logic [7:0]     alpha_e_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rece[i] = (TW+17)'(prod_d_ff[i]) * (TW+17)'(RECIP60);
         q0e[i] = 17'(rece[i] >> 22);
         q60e[i] = ((TW+1)'(q0e[i]) << 6) - ((TW+1)'(q0e[i]) << 2);
      end
   end

   always_ff @(posedge clock) begin
      if (ene) begin
         for (int i = 0; i < 3; i++) begin
            quo_e_ff[i] <= (q60e[i] > (TW+1)'(prod_d_ff[i])) ? q0e[i] - 17'd1 : q0e[i];
            seg_e_ff[i] <= seg_d_ff[i];
         end
         m1_e_ff    <= m1_d_ff;
         m2_e_ff    <= m2_d_ff;
         lum_e_ff   <= lum_d_ff;
         grey_e_ff  <= grey_d_ff;
         alpha_e_ff <= alpha_d_ff;
      end
   end

   // ---------------- stage F: leg value, back to channels, output register ----------------
   logic [FW:0] vf [3];
   logic [7:0]  chf [3];
   logic [7:0]  greyf;
   logic [31:0] rsp_data_ff;

   always_comb begin
      greyf = hcs_pkg::to_channel({1'b0, lum_e_ff});
      for (int i = 0; i < 3; i++) begin
         case (seg_e_ff[i])
            SEG_RISE, SEG_FALL: vf[i] = {1'b0, m1_e_ff} + (FW+1)'(quo_e_ff[i]);
            SEG_HIGH:           vf[i] = {1'b0, m2_e_ff};
            default:            vf[i] = {1'b0, m1_e_ff};
         endcase
         chf[i] = grey_e_ff ? greyf : hcs_pkg::to_channel(vf[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (enf) rsp_data_ff <= {alpha_e_ff, chf[2], chf[1], chf[0]};
   end

   assign rsp_tvalid = vf_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- checks ----------------
   logic rsp_grey_eq;

   // all three color channels of the output register agree
   assign rsp_grey_eq = (rsp_tdata[7:0] == rsp_tdata[15:8]) &&
                        (rsp_tdata[15:8] == rsp_tdata[23:16]);

   `HCS_ASSERT_NEXT(a_accept_fills, req_tvalid && req_tready, v1_ff)
   `HCS_ASSERT_NEXT(a_grey_equal, ve_ff && enf && grey_e_ff, rsp_grey_eq)
   `HCS_ASSERT_NEXT(a_shade_write, csr_wr && csr_paddr[2] == hcs_pkg::REG_SHADE, shade_ff == $past(csr_pwdata[17:0]))
   `HCS_ASSERT_SAME(a_stall_holds_out, rsp_tvalid && !rsp_tready, !enf)

endmodule

// ===== dv/hls_color_shade_tb.sv =====
module hls_color_shade_tb;

   localparam logic [2:0] ADDR_SHADE = 3'd0;
   localparam int         LATENCY    = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;     // red_in, green_in, blue_in, alpha_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // red_out, green_out, blue_out, alpha_out
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   hls_color_shade uut (.*);

   always #5 clock = ~clock;

   // shading factor as the testbench sees it
   logic [17:0] shade_q = 18'd65536;
   logic [31:0] pixel_q[$];
   int          n_bad = 0;
   int          n_pix = 0;
   int          n_rsp = 0;
   bit          quiet_rx = 1'b0;
   bit          hold_tx = 1'b0;

   // 16.16 helpers, truncating toward zero
   function automatic longint fmul(longint a, longint b);
      longint p;
      p = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> 16;
      return ((a < 0) != (b < 0)) ? -p : p;
   endfunction

   function automatic longint fdiv(longint a, longint b);
      longint q;
      if (b == 0) return 0;
      q = ((a < 0 ? -a : a) <<< 16) / (b < 0 ? -b : b);
      return ((a < 0) != (b < 0)) ? -q : q;
   endfunction

   function automatic logic [7:0] chan(longint v);
      longint r;
      if (v < 0) v = 0;
      r = (v * 255) >>> 16;
      return (r > 255) ? 8'hFF : 8'(r);
   endfunction

   function automatic logic [7:0] leg(longint m1, longint m2, longint h);
      longint d360, v;
      d360 = 360 <<< 16;
      if (h > d360) h -= d360;
      if (h < 0) h += d360;
      if (h < (60 <<< 16)) v = m1 + fmul(m2 - m1, h) / 60;
      else if (h < (180 <<< 16)) v = m2;
      else if (h < (240 <<< 16)) v = m1 + fmul(m2 - m1, (240 <<< 16) - h) / 60;
      else v = m1;
      return chan(v);
   endfunction

   // shaded pixel for one input pixel under the current factor
   function automatic logic [31:0] shade_pixel(logic [31:0] px, logic [17:0] f);
      longint r, g, b, mx, mn, l, s, h, d, m1, m2, one;
      logic [7:0] gr;
      one = 1 <<< 16;
      r = (longint'(px[7:0]) <<< 16) / 255;
      g = (longint'(px[15:8]) <<< 16) / 255;
      b = (longint'(px[23:16]) <<< 16) / 255;
      mx = r > g ? r : g;  if (b > mx) mx = b;
      mn = r < g ? r : g;  if (b < mn) mn = b;
      l = (mx + mn) / 2;
      s = 0;
      h = 0;
      if (mx != mn) begin
         d = mx - mn;
         s = (l <= one / 2) ? fdiv(d, mx + mn) : fdiv(d, 2 * one - mx - mn);
         if (r == mx) h = fdiv(g - b, d);
         else if (g == mx) h = 2 * one + fdiv(b - r, d);
         else h = 4 * one + fdiv(r - g, d);
         h *= 60;
         if (h < 0) h += 360 <<< 16;
      end
      l = fmul(l, longint'(f));
      if (l > one) l = one;
      s = fmul(s, longint'(f));
      if (s > one) s = one;
      if (s == 0) begin
         gr = chan(l);
         return {px[31:24], gr, gr, gr};
      end
      m2 = (l <= one / 2) ? fmul(l, one + s) : l + s - fmul(l, s);
      m1 = 2 * l - m2;
      return {px[31:24], leg(m1, m2, h - (120 <<< 16)), leg(m1, m2, h),
              leg(m1, m2, h + (120 <<< 16))};
   endfunction

   // result side: random stall, compare with the oldest expectation
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_rsp++;
            if (pixel_q.size() == 0) begin
               n_bad++;
               if (n_bad <= 10) $display("unexpected pixel %h", rsp_tdata);
            end else begin
               want = pixel_q.pop_front();
               if (want !== rsp_tdata) begin
                  n_bad++;
                  if (n_bad <= 10)
                     $display("pixel mismatch: exp r%0d g%0d b%0d a%0d got r%0d g%0d b%0d a%0d",
                              want[7:0], want[15:8], want[23:16], want[31:24],
                              rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                              rsp_tdata[31:24]);
               end
            end
         end
         rsp_tready <= quiet_rx || ($urandom_range(99) >= 24);
      end
   end

   // sender side: one pixel, with a random gap first unless hold_tx is set; valid stays up after the transfer
   task automatic send_pixel(logic [31:0] px, bit chk, logic [31:0] lit);
      logic [31:0] want;
      want = shade_pixel(px, shade_q);
      if (chk && want !== lit) begin
         n_bad++;
         if (n_bad <= 10) $display("table row %h: exp %h pred %h", px, lit, want);
      end
      while (!hold_tx && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixel_q.push_back(want);
      n_pix++;
   endtask

   // stop sending and wait until every expected pixel has come back
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // register write, setup then access
   task automatic write_shade(logic [17:0] v);
      csr_psel <= 1'b1;  csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_SHADE;  csr_pwdata <= 32'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;  csr_penable <= 1'b0;  csr_pwrite <= 1'b0;
      shade_q = v;
   endtask

   typedef struct {
      logic [31:0] px;
      bit          chk;
      logic [31:0] lit;
   } row_type;

   row_type table_rows[] = '{
      '{32'h00000000, 1, 32'h00000000},   // black
      '{32'hFFFFFFFF, 1, 32'hFFFFFFFF},   // white, grey path
      '{32'hA5808080, 0, 0},              // mid grey
      '{32'h120000FF, 0, 0},              // pure red
      '{32'h3400FF00, 0, 0},              // pure green
      '{32'h56FF0000, 0, 0},              // pure blue
      '{32'h00FF00FF, 0, 0},              // magenta: negative hue
      '{32'hFF00FFFF, 0, 0},              // yellow
      '{32'h80FFFF00, 0, 0},              // cyan
      '{32'h01010100, 0, 0},              // dark, light below half
      '{32'h02FEFFFF, 0, 0},              // bright, light above half
      '{32'h7F2040C0, 0, 0},
      '{32'hC0C04020, 0, 0},
      '{32'h0000FF01, 0, 0}               // hue just below 120
   };

   logic [17:0] factors[] = '{18'd65536, 18'h14CCD, 18'hB333, 18'd0, 18'h3FFFF};

   initial begin
      logic [31:0] px;
      int k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed rows under the reset factor
      foreach (table_rows[i]) send_pixel(table_rows[i].px, table_rows[i].chk,
                                        table_rows[i].lit);
      drain();
      foreach (factors[f]) begin
         write_shade(factors[f]);
         for (k = 0; k < 120; k++) begin
            px = $urandom();
            case ($urandom_range(5))
               0: px[23:0] = {3{px[7:0]}};          // grey
               1: px[15:8] = px[7:0];               // two equal channels
               default: ;
            endcase
            quiet_rx = (k >= 40 && k < 70);
            hold_tx  = quiet_rx;
            if (k == 80) begin
               // wait for the pipe to empty mid phase
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (pixel_q.size() != 0) @(posedge clock);
            end
            send_pixel(px, 0, 0);
         end
         drain();
      end
      $display("covered %0d pixels, %0d results, %0d shade settings incl. 0 and max",
               n_pix, n_rsp, factors.size());
      if (n_bad == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
